// ===== src/sis_pkg.sv =====
package sis_pkg;

    // Default store depth and key width.
    localparam int unsigned MAX_ITEMS_DEF = 16;
    localparam int unsigned KEY_BITS_DEF  = 32;

    // Fixed field widths of the channels.
    localparam int unsigned AREA_BITS = 32;
    localparam int unsigned IDX_BITS  = 6;

    // Per-cycle commands that the controller broadcasts to every cell.
    typedef struct packed {
        logic insert;   // place the broadcast key into the chain
        logic drain;    // shift the whole chain one place toward cell 0
    } t_cell_ctrl;

endpackage

// ===== src/sis_if.sv =====
// Input channel: one key per request.
interface sis_in_if;
    logic                             valid;
    logic                             ready;
    logic [sis_pkg::AREA_BITS-1:0]    area_key;
    logic                             last_key;

    modport source (output valid, output area_key, output last_key, input ready);
    modport sink   (input valid, input area_key, input last_key, output ready);
endinterface

// Output channel: one sorted arrival index per request.
interface sis_out_if;
    logic                             valid;
    logic                             ready;
    logic [sis_pkg::IDX_BITS-1:0]     sorted_index;
    logic                             last_index;
    logic                             overflowed;

    modport source (output valid, output sorted_index, output last_index,
                    output overflowed, input ready);
    modport sink   (input valid, input sorted_index, input last_index,
                    input overflowed, output ready);
endinterface

// ===== src/sis_cell.sv =====
module sis_cell #(
    parameter int unsigned KEY_BITS = sis_pkg::KEY_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sis_pkg::t_cell_ctrl           i_ctrl,
    // Broadcast key and its arrival index.
    input  logic [KEY_BITS-1:0]           i_key,
    input  logic [sis_pkg::IDX_BITS-1:0]  i_index,
    // Left neighbor (toward cell 0).
    input  logic                          i_prev_valid,
    input  logic [KEY_BITS-1:0]           i_prev_key,
    input  logic [sis_pkg::IDX_BITS-1:0]  i_prev_index,
    input  logic                          i_prev_gt,
    // Right neighbor (away from cell 0).
    input  logic                          i_next_valid,
    input  logic [KEY_BITS-1:0]           i_next_key,
    input  logic [sis_pkg::IDX_BITS-1:0]  i_next_index,
    // Own contents and compare result.
    output logic                          o_valid,
    output logic [KEY_BITS-1:0]           o_key,
    output logic [sis_pkg::IDX_BITS-1:0]  o_index,
    output logic                          o_gt
);

    logic                          r_valid;
    logic [KEY_BITS-1:0]           r_key;
    logic [sis_pkg::IDX_BITS-1:0]  r_index;

    // An empty cell counts as holding a key above every other key, so the
    // new key lands in front of the first strictly greater entry.
    assign o_gt    = !r_valid || (i_key < r_key);
    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_index = r_index;

    // Occupancy bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.drain) begin
            r_valid <= i_next_valid;
        end else if (i_ctrl.insert && o_gt) begin
            r_valid <= i_prev_gt ? i_prev_valid : 1'b1;
        end
    end

    // Key and index: shift right behind the insertion point, shift left on drain.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.drain) begin
            r_key   <= i_next_key;
            r_index <= i_next_index;
        end else if (i_ctrl.insert && o_gt) begin
            if (i_prev_gt) begin
                r_key   <= i_prev_key;
                r_index <= i_prev_index;
            end else begin
                r_key   <= i_key;
                r_index <= i_index;
            end
        end
    end

endmodule

// ===== src/stable_index_sorter_by_key_core.sv =====
// Stable insertion argsort over one set of keys at a time.
//
// i_in (sink): one area key per request, last_key marks the final key of a
// set. Only the low KEY_BITS bits of a key are compared, as unsigned values.
// o_out (source): after the last key, the arrival indices in ascending key
// order, one per request; equal keys keep arrival order. last_index marks
// the final result and overflowed tells that keys beyond MAX_ITEMS were
// dropped from the set.
//
// Throughput: one key per cycle while a set is being filled; the key is
// compared in every cell of the chain at once and the chain shifts in the
// same cycle. After the last key is accepted, the head of the chain moves
// into the output register, then one result per cycle while o_out is ready,
// n results for n stored keys. i_in.ready is low from the cycle after the
// last key until the chain has been shifted out through cell 0. A stall on
// o_out holds the output register and stops the chain shift. Reset empties
// the chain and the counters; no clearing pass is needed.
module stable_index_sorter_by_key_core #(
    parameter int unsigned MAX_ITEMS = sis_pkg::MAX_ITEMS_DEF,
    parameter int unsigned KEY_BITS  = sis_pkg::KEY_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sis_in_if.sink     i_in,
    sis_out_if.source  o_out
);

    localparam int unsigned CNT_BITS = $clog2(MAX_ITEMS + 1);

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    t_state                        r_state;
    logic [CNT_BITS-1:0]           r_count;
    logic                          r_ovf;
    logic                          r_out_valid;
    logic [sis_pkg::IDX_BITS-1:0]  r_out_index;
    logic                          r_out_last;
    logic                          r_out_ovf;

    sis_pkg::t_cell_ctrl           w_ctrl;
    logic                          w_accept;
    logic                          w_full;
    logic                          w_load;
    logic [KEY_BITS-1:0]           w_key;
    logic [sis_pkg::IDX_BITS-1:0]  w_index;
    logic [MAX_ITEMS-1:0]          w_valid;
    logic [MAX_ITEMS-1:0]          w_gt;
    logic [KEY_BITS-1:0]           w_cell_key   [MAX_ITEMS];
    logic [sis_pkg::IDX_BITS-1:0]  w_cell_index [MAX_ITEMS];

    // Input handshake and broadcast values.
    assign i_in.ready = (r_state == ST_FILL);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = (r_count == CNT_BITS'(MAX_ITEMS));
    assign w_key      = KEY_BITS'(i_in.area_key);
    assign w_index    = sis_pkg::IDX_BITS'(r_count);

    // Drain takes the head of the chain whenever the output register frees up.
    assign w_load = (r_state == ST_DRAIN) && (!r_out_valid || o_out.ready);

    assign w_ctrl.insert = w_accept && !w_full;
    assign w_ctrl.drain  = w_load;

    // Chain of cells, cell 0 holds the smallest key.
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        logic                          w_prev_valid;
        logic [KEY_BITS-1:0]           w_prev_key;
        logic [sis_pkg::IDX_BITS-1:0]  w_prev_index;
        logic                          w_prev_gt;
        logic                          w_next_valid;
        logic [KEY_BITS-1:0]           w_next_key;
        logic [sis_pkg::IDX_BITS-1:0]  w_next_index;

        if (g == 0) begin : g_head
            assign w_prev_valid = 1'b0;
            assign w_prev_key   = '0;
            assign w_prev_index = '0;
            assign w_prev_gt    = 1'b0;
        end else begin : g_body
            assign w_prev_valid = w_valid[g-1];
            assign w_prev_key   = w_cell_key[g-1];
            assign w_prev_index = w_cell_index[g-1];
            assign w_prev_gt    = w_gt[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_tail
            assign w_next_valid = 1'b0;
            assign w_next_key   = '0;
            assign w_next_index = '0;
        end else begin : g_inner
            assign w_next_valid = w_valid[g+1];
            assign w_next_key   = w_cell_key[g+1];
            assign w_next_index = w_cell_index[g+1];
        end

        sis_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_key        (w_key),
            .i_index      (w_index),
            .i_prev_valid (w_prev_valid),
            .i_prev_key   (w_prev_key),
            .i_prev_index (w_prev_index),
            .i_prev_gt    (w_prev_gt),
            .i_next_valid (w_next_valid),
            .i_next_key   (w_next_key),
            .i_next_index (w_next_index),
            .o_valid      (w_valid[g]),
            .o_key        (w_cell_key[g]),
            .o_index      (w_cell_index[g]),
            .o_gt         (w_gt[g])
        );
    end

    // Set control: fill count, overflow flag and fill/drain sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            unique case (r_state)
                ST_FILL: begin
                    if (w_accept) begin
                        if (w_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count <= r_count + CNT_BITS'(1);
                        end
                        if (i_in.last_key) begin
                            r_state <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (w_load && !w_valid[1]) begin
                        r_state <= ST_FILL;
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_FILL;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_index <= w_cell_index[0];
            r_out_last  <= !w_valid[1];
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sorted_index = r_out_index;
    assign o_out.last_index   = r_out_last;
    assign o_out.overflowed   = r_out_ovf;

`ifndef SYNTHESIS
    // Occupied cells always form one run starting at cell 0.
    a_valid_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot({1'b0, w_valid} + (MAX_ITEMS + 1)'(1)))
        else $error("chain occupancy has a gap");

    // While filling, the count tracks the number of occupied cells.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL) |-> ($countones(w_valid) == int'(r_count)))
        else $error("fill count differs from chain occupancy");

    // The count never runs past the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(MAX_ITEMS))
        else $error("fill count beyond store depth");

    // A drain never starts or runs on an empty chain.
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> w_valid[0])
        else $error("drain with empty chain");

    // Taking the final entry leaves the chain empty and reopens the input.
    a_drain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !w_valid[1]) |=> ((r_state == ST_FILL) && !w_valid[0]
                                     && r_out_last))
        else $error("set did not close after final result");
`endif

endmodule
